FILE: rtl/contiguous_fit_allocator_assert.svh
// Assertion macros for the contiguous fit allocator checker.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define CFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cfa_pkg.sv
package cfa_pkg;

  // Command codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Fit policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Register index (paddr[2])
  localparam logic REG_FIT_POLICY = 1'b0;

  // Width of the request_size field
  localparam int SIZE_BITS = 9;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE,
    ST_DECIDE,
    ST_WRITE,
    ST_REL,
    ST_DONE
  } state_t;

  // Control from the engine to the hole tracker
  typedef struct packed {
    logic clear;    // start of a new search
    logic step;     // one unit's tag is on the read port
    logic is_free;  // that unit is free
    logic close;    // end of table, close any open run
  } hole_ctl_t;

endpackage

FILE: rtl/cfa_regs.sv
module cfa_regs
  import cfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [1:0]  fit_policy
);

  logic wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POL_FIRST;
    end else if (wr && paddr[2] == REG_FIT_POLICY) begin
      fit_policy <= pwdata[1:0];
    end
  end

  // read back
  assign prdata = (paddr[2] == REG_FIT_POLICY) ? {30'd0, fit_policy} : 32'd0;

endmodule

FILE: rtl/cfa_hole.sv
module cfa_hole
  import cfa_pkg::*;
#(
  parameter int UNIT_COUNT = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  hole_ctl_t                              ctl,
  input  logic [$clog2(UNIT_COUNT)-1:0]          idx,
  input  logic [1:0]                             policy,
  input  logic [((($clog2(UNIT_COUNT+1)) > SIZE_BITS) ?
                 $clog2(UNIT_COUNT+1) : SIZE_BITS)-1:0] size,
  output logic                                   found,
  output logic [$clog2(UNIT_COUNT)-1:0]          best_pos
);

  localparam int UW = $clog2(UNIT_COUNT);
  localparam int LW = $clog2(UNIT_COUNT + 1);
  localparam int CW = (LW > SIZE_BITS) ? LW : SIZE_BITS;

  logic [UW-1:0] run_start;
  logic [LW-1:0] run_len;
  logic [LW-1:0] best_len;
  logic          have;
  logic          grow;
  logic          eval;
  logic          fits;
  logic          take;

  assign grow = ctl.step && ctl.is_free;
  assign eval = (run_len != '0) && ((ctl.step && !ctl.is_free) || ctl.close);
  assign fits = CW'(run_len) >= size;

  // does the run that just ended beat the current pick
  always_comb begin
    case (policy)
      POL_FIRST: take = fits && !have;
      POL_BEST:  take = fits && (!have || run_len < best_len);
      POL_WORST: take = !have || run_len > best_len;
      default:   take = 1'b0;
    endcase
  end

  // run length and pick flag
  always_ff @(posedge clk) begin
    if (rst) begin
      run_len <= '0;
      have    <= 1'b0;
    end else if (ctl.clear) begin
      run_len <= '0;
      have    <= 1'b0;
    end else if (grow) begin
      run_len <= run_len + LW'(1);
    end else if (eval) begin
      run_len <= '0;
      if (take) begin
        have <= 1'b1;
      end
    end
  end

  // run start and picked hole
  always_ff @(posedge clk) begin
    if (grow && run_len == '0) begin
      run_start <= idx;
    end
    if (!ctl.clear && !grow && eval && take) begin
      best_pos <= run_start;
      best_len <= run_len;
    end
  end

  assign found = have && (CW'(best_len) >= size);

endmodule

FILE: rtl/cfa_engine.sv
module cfa_engine
  import cfa_pkg::*;
#(
  parameter int UNIT_COUNT = 256,
  parameter int OWNER_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] fit_policy,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [7:0] owner_id,
  input  logic [8:0] request_size,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       success,
  output logic [7:0] start_unit
);

  localparam int UW = $clog2(UNIT_COUNT);
  localparam int LW = $clog2(UNIT_COUNT + 1);
  localparam int CW = (LW > SIZE_BITS) ? LW : SIZE_BITS;

  typedef logic [OWNER_BITS-1:0] owner_t;

  state_t          state, state_next;
  logic [LW-1:0]   cnt, cnt_next;
  owner_t          own, own_in;
  logic [CW-1:0]   size, size_in;
  logic            alloc_ok;
  logic            accept;
  logic            res_success, res_success_next;
  logic [7:0]      res_start, res_start_next;
  logic            load_out;

  // owner table memory
  owner_t          mem [UNIT_COUNT];
  logic            rd_en;
  logic            rd_valid;
  logic [UW-1:0]   rd_idx;
  owner_t          rd_data;
  logic            last;
  logic            we;
  logic [UW-1:0]   waddr;
  owner_t          wdata;

  hole_ctl_t       hctl;
  logic            found;
  logic [UW-1:0]   best_pos;

  cfa_hole #(
    .UNIT_COUNT(UNIT_COUNT)
  ) u_hole (
    .clk      (clk),
    .rst      (rst),
    .ctl      (hctl),
    .idx      (rd_idx),
    .policy   (fit_policy),
    .size     (size),
    .found    (found),
    .best_pos (best_pos)
  );

  assign own_in   = owner_t'(owner_id);
  assign size_in  = CW'(request_size);
  assign alloc_ok = (own_in != '0) && (size_in != '0) &&
                    (size_in <= CW'(UNIT_COUNT)) &&
                    (fit_policy == POL_FIRST || fit_policy == POL_BEST ||
                     fit_policy == POL_WORST);
  assign accept   = in_valid && !in_stall;
  assign last     = rd_valid && (rd_idx == UW'(UNIT_COUNT - 1));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[cnt[UW-1:0]];
    end
    rd_idx <= cnt[UW-1:0];
  end

  // next state and datapath controls
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    in_stall         = 1'b1;
    rd_en            = 1'b0;
    we               = 1'b0;
    waddr            = cnt[UW-1:0];
    wdata            = '0;
    hctl             = '0;
    load_out         = 1'b0;
    res_success_next = res_success;
    res_start_next   = res_start;
    unique case (state)
      ST_CLEAR: begin
        we       = 1'b1;
        cnt_next = cnt + LW'(1);
        if (cnt == LW'(UNIT_COUNT - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cnt_next = '0;
        if (in_valid) begin
          if (command == CMD_RELEASE) begin
            res_success_next = 1'b1;
            res_start_next   = 8'd0;
            state_next       = (own_in != '0) ? ST_REL : ST_DONE;
          end else if (alloc_ok) begin
            hctl.clear = 1'b1;
            state_next = ST_SCAN;
          end else begin
            res_success_next = 1'b0;
            res_start_next   = 8'd0;
            state_next       = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        rd_en = (cnt != LW'(UNIT_COUNT));
        if (rd_en) begin
          cnt_next = cnt + LW'(1);
        end
        hctl.step    = rd_valid;
        hctl.is_free = (rd_data == '0);
        if (last) begin
          state_next = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        hctl.close = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cnt_next = '0;
        if (found) begin
          res_success_next = 1'b1;
          res_start_next   = 8'(best_pos);
          state_next       = ST_WRITE;
        end else begin
          res_success_next = 1'b0;
          res_start_next   = 8'd0;
          state_next       = ST_DONE;
        end
      end
      ST_WRITE: begin
        we       = 1'b1;
        waddr    = best_pos + cnt[UW-1:0];
        wdata    = own;
        cnt_next = cnt + LW'(1);
        if (CW'(cnt) == size - CW'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_REL: begin
        rd_en = (cnt != LW'(UNIT_COUNT));
        if (rd_en) begin
          cnt_next = cnt + LW'(1);
        end
        // read-modify-write one entry behind the read address
        we    = rd_valid && (rd_data == own);
        waddr = rd_idx;
        if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      rd_valid <= rd_en;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      own  <= own_in;
      size <= size_in;
    end
    res_success <= res_success_next;
    res_start   <= res_start_next;
    if (load_out) begin
      success    <= res_success;
      start_unit <= res_start;
    end
  end

endmodule

FILE: rtl/contiguous_fit_allocator.sv
// Contiguous fit allocator: one owner tag per unit, 0 meaning free.
// Input channel (in_valid/in_stall) carries command, owner_id, request_size.
// An allocate scans the table for holes under fit_policy and tags the chosen
// run; a release clears every unit of the owner. Each item gives one result
// item (success, start_unit) on out_valid/out_stall.
// The table sits in one single-port-write, single-port-read RAM with a
// registered read; the scan reads one unit a cycle, so the RAM port sets
// the rate. One item at a time: an allocate scans, then writes the run;
// a release makes a read-modify-write sweep; a rejected allocate or a
// release of owner 0 goes straight to its result.
// Reset clears fit_policy and runs a clearing pass over every unit of the
// table, with in_stall high; the APB port takes writes meanwhile.
// The result sits in an output register; while out_stall is high it holds,
// and a following finished item waits in the engine until it is taken.
// fit_policy must be written only while idle; the block does not enforce it.
module contiguous_fit_allocator
  import cfa_pkg::*;
#(
  parameter int UNIT_COUNT = 256,
  parameter int OWNER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  owner_id,
  input  logic [8:0]  request_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        success,
  output logic [7:0]  start_unit
);

  logic [1:0] fit_policy;

  cfa_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fit_policy (fit_policy)
  );

  cfa_engine #(
    .UNIT_COUNT (UNIT_COUNT),
    .OWNER_BITS (OWNER_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .fit_policy   (fit_policy),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .owner_id     (owner_id),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .success      (success),
    .start_unit   (start_unit)
  );

endmodule

FILE: rtl/cfa_checker.sv
`include "contiguous_fit_allocator_assert.svh"

module cfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        success,
  input logic [7:0]  start_unit
);

  // table clearing pass keeps the input closed right after reset
  `CFA_ASSERT_NOW(a_clear_stall, $past(rst), in_stall, "input open during clearing pass")

  // one item in flight at a time
  `CFA_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken too early")

  // a failed allocation reports unit 0
  `CFA_ASSERT_NOW(a_fail_zero, out_valid && !success, start_unit == 8'd0, "failed result with start")

  // stalled result holds
  `CFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(success) && $stable(start_unit),
                   "stalled result changed")

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (.*);

FILE: dv/tb_top.sv
module tb_top;
  import cfa_pkg::*;

  localparam int UNITS = 256;
  // Longest item: full scan plus a 256-unit write, with some margin
  localparam int LATENCY_CYCLES = 600;
  localparam int PHASES = 7;
  localparam logic [1:0] POL_UNUSED = 2'd3;
  localparam logic REG_SPARE = 1'b1;

  typedef struct {
    logic       command;
    logic [7:0] owner;
    logic [8:0] size;
  } alloc_req_t;

  typedef struct {
    logic       success;
    logic [7:0] start_unit;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = CMD_ALLOC;
  logic [7:0]  owner_id = '0;
  logic [8:0]  request_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        success;
  logic [7:0]  start_unit;

  // Shadow of the owner table and the policy register
  logic [7:0] unit_tag [UNITS];
  logic [1:0] fit_rule = POL_FIRST;

  alloc_req_t    pending_reqs[$];
  alloc_result_t expected_results[$];

  int  sender_idle_pct = 0;
  int  receiver_stall_pct = 0;
  bit  in_accepted = 1'b0;
  int  fail_count = 0;
  int  items_taken = 0;
  int  results_checked = 0;
  int  n_placed = 0;
  int  n_refused = 0;
  int  n_released = 0;

  logic [1:0] phase_rule [PHASES] =
    '{POL_FIRST, POL_BEST, POL_WORST, POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED};
  int phase_sender [PHASES] = '{0, 49, 0, 29, 29, 0, 49};
  int phase_receiver [PHASES] = '{0, 0, 49, 29, 29, 0, 0};
  int phase_items [PHASES] = '{160, 160, 160, 160, 160, 160, 60};

  contiguous_fit_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .owner_id     (owner_id),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .success      (success),
    .start_unit   (start_unit)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one item to the shadow table and work out its result
  task automatic apply_request(input logic cmd, input logic [7:0] owner,
                               input logic [8:0] size, output alloc_result_t res);
    int  u;
    int  run_at;
    int  run_len;
    int  pick_at;
    int  pick_len;
    bit  found;
    res.success = 1'b0;
    res.start_unit = '0;
    if (cmd == CMD_RELEASE) begin
      n_released++;
      if (owner != 0) begin
        for (u = 0; u < UNITS; u++) begin
          if (unit_tag[u] == owner) unit_tag[u] = '0;
        end
      end
      res.success = 1'b1;
      return;
    end
    if (owner == 0 || size == 0 || size > UNITS || fit_rule == POL_UNUSED) begin
      n_refused++;
      return;
    end
    // Walk the holes; one extra step past the end closes the last one
    run_at = 0;
    run_len = 0;
    pick_at = 0;
    pick_len = 0;
    found = 1'b0;
    for (u = 0; u <= UNITS; u++) begin
      if (u < UNITS && unit_tag[u] == 0) begin
        if (run_len == 0) run_at = u;
        run_len++;
      end else begin
        if (run_len != 0) begin
          case (fit_rule)
            POL_FIRST: begin
              if (!found && run_len >= size) begin
                found = 1'b1;
                pick_at = run_at;
                pick_len = run_len;
              end
            end
            POL_BEST: begin
              if (run_len >= size && (!found || run_len < pick_len)) begin
                found = 1'b1;
                pick_at = run_at;
                pick_len = run_len;
              end
            end
            default: begin
              if (!found || run_len > pick_len) begin
                found = 1'b1;
                pick_at = run_at;
                pick_len = run_len;
              end
            end
          endcase
        end
        run_len = 0;
      end
    end
    if (!found || pick_len < size) begin
      n_refused++;
      return;
    end
    for (u = pick_at; u < pick_at + size; u++) unit_tag[u] = owner;
    res.success = 1'b1;
    res.start_unit = 8'(pick_at);
    n_placed++;
  endtask

  function automatic logic [7:0] pick_owner();
    // Mostly a small set of owners so that releases find something
    if ($urandom_range(0, 99) < 80) return 8'($urandom_range(1, 12));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic alloc_req_t random_request();
    alloc_req_t req;
    int roll;
    roll = $urandom_range(0, 99);
    req.size = 9'($urandom_range(0, 511));
    if (roll < 28) begin
      req.command = CMD_RELEASE;
      req.owner = (roll < 2) ? 8'd0 : pick_owner();
    end else begin
      req.command = CMD_ALLOC;
      req.owner = (roll < 30) ? 8'd0 : pick_owner();
      roll = $urandom_range(0, 99);
      if (roll < 2) req.size = '0;
      else if (roll < 4) req.size = 9'($urandom_range(257, 511));
      else if (roll < 8) req.size = 9'($urandom_range(129, 256));
      else if (roll < 20) req.size = 9'($urandom_range(33, 128));
      else req.size = 9'($urandom_range(1, 32));
    end
    return req;
  endfunction

  task automatic queue_item(input logic cmd, input logic [7:0] owner, input logic [8:0] size);
    alloc_req_t req;
    req.command = cmd;
    req.owner = owner;
    req.size = size;
    pending_reqs = {pending_reqs, req};
  endtask

  // Checked at the rising edge, where the item queue is stable
  task automatic wait_all_results();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic apb_write(input logic index, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic index, output logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {index, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_policy_reg();
    logic [31:0] readback;
    apb_read(REG_FIT_POLICY, readback);
    if (readback !== {30'd0, fit_rule}) begin
      fail_count++;
      if (fail_count <= 10)
        $display("fit_policy readback: expected %0d, got %0h", fit_rule, readback);
    end
  endtask

  // Change the policy once the block has gone quiet
  task automatic set_fit_rule(input logic [31:0] value);
    wait_all_results();
    repeat (8) @(negedge clk);
    apb_write(REG_SPARE, $urandom());
    apb_write(REG_FIT_POLICY, value);
    fit_rule = value[1:0];
    check_policy_reg();
  endtask

  // Input side: note each item the block takes and predict its result
  always @(posedge clk) begin : accept_side
    alloc_result_t res;
    in_accepted = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      in_accepted = 1'b1;
      apply_request(command, owner_id, request_size, res);
      expected_results = {expected_results, res};
      items_taken++;
    end
  end

  // Item driver: payload holds until taken
  always @(negedge clk) begin : item_driver
    alloc_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        command <= req.command;
        owner_id <= req.owner;
        request_size <= req.size;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    alloc_result_t exp_res;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: success %0b start_unit %0d", success, start_unit);
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (success !== exp_res.success || start_unit !== exp_res.start_unit) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: expected success %0b start_unit %0d, got %0b %0d",
                     results_checked, exp_res.success, exp_res.start_unit,
                     success, start_unit);
        end
      end
    end
  end

  initial begin
    int p;
    int n;
    for (n = 0; n < UNITS; n++) unit_tag[n] = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Register comes out of reset at first fit
    check_policy_reg();
    set_fit_rule(32'h0000_0000);

    // Directed: rejects, full table, fragmentation under first fit
    queue_item(CMD_ALLOC, 8'd5, 9'd0);
    queue_item(CMD_ALLOC, 8'd0, 9'd4);
    queue_item(CMD_ALLOC, 8'd7, 9'd257);
    queue_item(CMD_ALLOC, 8'd7, 9'd511);
    queue_item(CMD_ALLOC, 8'd255, 9'd256);
    queue_item(CMD_ALLOC, 8'd1, 9'd1);
    queue_item(CMD_RELEASE, 8'd0, 9'd0);
    queue_item(CMD_RELEASE, 8'd255, 9'd0);
    queue_item(CMD_ALLOC, 8'h80, 9'd10);
    queue_item(CMD_ALLOC, 8'h40, 9'd20);
    queue_item(CMD_ALLOC, 8'h81, 9'd5);
    queue_item(CMD_ALLOC, 8'h41, 9'd3);
    queue_item(CMD_ALLOC, 8'h20, 9'd2);
    queue_item(CMD_RELEASE, 8'h40, 9'd0);
    queue_item(CMD_RELEASE, 8'h41, 9'd0);
    queue_item(CMD_ALLOC, 8'h11, 9'd2);

    // Best fit: exact hole, smallest hole, then nothing fits
    set_fit_rule(32'hFFFF_FFFD);
    queue_item(CMD_ALLOC, 8'h12, 9'd3);
    queue_item(CMD_ALLOC, 8'h13, 9'd17);
    queue_item(CMD_ALLOC, 8'h14, 9'd217);

    // Worst fit: largest hole, exact fill, then no room
    set_fit_rule(32'h8000_0002);
    queue_item(CMD_ALLOC, 8'h15, 9'd4);
    queue_item(CMD_ALLOC, 8'h16, 9'd212);
    queue_item(CMD_ALLOC, 8'h17, 9'd2);
    queue_item(CMD_RELEASE, 8'h16, 9'h1FF);

    // Random phases over policies and handshake pressure
    for (p = 0; p < PHASES; p++) begin
      if (phase_rule[p] == POL_UNUSED) set_fit_rule(32'hFFFF_FFFF);
      else set_fit_rule(($urandom() & 32'hFFFF_FFFC) | {30'd0, phase_rule[p]});
      sender_idle_pct = phase_sender[p];
      receiver_stall_pct = phase_receiver[p];
      for (n = 0; n < phase_items[p]; n++) begin
        // Sender holds off mid-phase until the block has drained
        if (p == 2 && n == phase_items[p] / 2) wait_all_results();
        pending_reqs = {pending_reqs, random_request()};
      end
    end

    wait_all_results();
    repeat (LATENCY_CYCLES) @(negedge clk);
    fail_count += expected_results.size();
    $display("Covered %0d items: %0d placed, %0d refused, %0d releases", items_taken,
             n_placed, n_refused, n_released);
    $display("under first, best, worst and unused policy; %0d results compared, %0d failures",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cfa_pkg.sv
rtl/cfa_regs.sv
rtl/cfa_hole.sv
rtl/cfa_engine.sv
rtl/contiguous_fit_allocator.sv
rtl/cfa_checker.sv
dv/tb_top.sv
